/* rtl/gcsa_pkg.sv */
// ----------------------------------------------------------------------------
// Glyph cache shelf allocator package
// Shared types, register indexes, status codes and size constants.
// ----------------------------------------------------------------------------
package gcsa_pkg;

    localparam int unsigned CACHE_ENTRIES_DEF = 256;
    localparam int unsigned COORD_BITS        = 13;
    localparam int unsigned GLYPH_BITS        = 16;

    // Configuration register indexes.
    localparam logic REG_ATLAS_WIDTH  = 1'b0;
    localparam logic REG_ATLAS_HEIGHT = 1'b1;

    localparam logic [COORD_BITS-1:0] ATLAS_RESET = COORD_BITS'(1024);

    // Result status codes.
    localparam logic [1:0] ST_HIT    = 2'd0;
    localparam logic [1:0] ST_PLACED = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [GLYPH_BITS-1:0] glyph_id;
        logic [COORD_BITS-1:0] bmp_width;
        logic [COORD_BITS-1:0] bmp_height;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [COORD_BITS-1:0] rect_left;
        logic [COORD_BITS-1:0] rect_top;
        logic [COORD_BITS-1:0] rect_right;
        logic [COORD_BITS-1:0] rect_bottom;
        logic                  evicted;
        logic [GLYPH_BITS-1:0] evicted_id;
    } res_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] bottom;
    } rect_t;

    typedef struct packed {
        logic [GLYPH_BITS-1:0] glyph;
        rect_t                 rect;
    } entry_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic scan;
        logic ev_entry;
        logic evict;
        logic place;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic hit;
        logic scan_done;
        logic table_full;
    } stat_t;

endpackage

/* rtl/glyph_cache_shelf_allocator_top.sv */
// ----------------------------------------------------------------------------
// Glyph cache shelf allocator
// Looks up glyph rectangles and packs new glyphs onto atlas shelves.
// ----------------------------------------------------------------------------
// Usage:
// A request beat is taken when start is high and busy is low; req carries
// the glyph id and bitmap size. Exactly one result beat follows, shown on
// result for a single cycle with result_valid high; the receiver must take
// it then, since it cannot stall the block. busy drops in the same cycle
// the result appears, so the next request may start right away.
// A hit ends the scan at the matching entry; a miss scans every filled
// slot and then places the glyph, first evicting the oldest entry when the
// table is full. The entry memory scan reads one slot per cycle over the
// table slots ever filled, up to CACHE_ENTRIES.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// sets atlas width and height; it is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
// Reset empties the table, zeroes the shelf cursor and restores both atlas
// dimensions to 1024. No clearing pass is needed.
// ----------------------------------------------------------------------------
module glyph_cache_shelf_allocator_top
#(
    parameter int unsigned CACHE_ENTRIES = gcsa_pkg::CACHE_ENTRIES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  gcsa_pkg::req_t                  req,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [gcsa_pkg::COORD_BITS-1:0] cfg_data,
    output logic                            result_valid,
    output gcsa_pkg::res_t                  result
);

    gcsa_pkg::cmd_t  cmd;
    gcsa_pkg::stat_t stat;

    // Configuration writes are always accepted.
    assign cfg_ready = 1'b1;

    gcsa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    gcsa_dp
    #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req          (req),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* rtl/gcsa_ctrl.sv */
// ----------------------------------------------------------------------------
// Glyph cache controller
// Sequences one request: table scan, then on a miss an optional eviction and placement.
// ----------------------------------------------------------------------------
module gcsa_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  gcsa_pkg::stat_t stat,
    output gcsa_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MISS  = 3'd2;
    localparam logic [2:0] S_EVICT = 3'd3;
    localparam logic [2:0] S_PLACE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.scan_done)
                begin
                    state_next = S_MISS;
                end
            end
            S_MISS:
            begin
                if (stat.table_full)
                begin
                    cmd.ev_entry = 1'b1;
                    state_next   = S_EVICT;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_EVICT:
            begin
                cmd.evict  = 1'b1;
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* rtl/gcsa_dp.sv */
// ----------------------------------------------------------------------------
// Glyph cache datapath
// Entry and order memories, occupancy tracking, shelf cursor and result.
// ----------------------------------------------------------------------------
module gcsa_dp
#(
    parameter int unsigned CACHE_ENTRIES = gcsa_pkg::CACHE_ENTRIES_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  gcsa_pkg::cmd_t                   cmd,
    output gcsa_pkg::stat_t                  stat,
    input  gcsa_pkg::req_t                   req,
    input  logic                             cfg_valid,
    input  logic                             cfg_index,
    input  logic [gcsa_pkg::COORD_BITS-1:0]  cfg_data,
    output logic                             result_valid,
    output gcsa_pkg::res_t                   result
);

    localparam int unsigned IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(CACHE_ENTRIES + 1);
    localparam int unsigned CB = gcsa_pkg::COORD_BITS;
    localparam logic [CW-1:0] N_CNT     = CW'(CACHE_ENTRIES);
    localparam logic [CW:0]   N_SUM     = (CW+1)'(CACHE_ENTRIES);
    localparam logic [IW-1:0] LAST_SLOT = IW'(CACHE_ENTRIES - 1);

    // Memories: entry store and insertion-order ring.
    gcsa_pkg::entry_t entry_mem [CACHE_ENTRIES];
    logic [IW-1:0]    ring_mem  [CACHE_ENTRIES];

    gcsa_pkg::entry_t ent_q;
    logic [IW-1:0]    ring_q;
    logic             ent_we;
    logic [IW-1:0]    ent_wa;
    logic [IW-1:0]    ent_ra;
    gcsa_pkg::entry_t ent_wd;
    logic             ring_we;
    logic [IW-1:0]    ring_wa;

    // Registers.
    gcsa_pkg::req_t   req_reg, req_next;
    logic [CB-1:0]    aw_reg, aw_next;
    logic [CB-1:0]    ah_reg, ah_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             hole_v_reg, hole_v_next;
    logic [IW-1:0]    hole_slot_reg, hole_slot_next;
    logic [IW-1:0]    head_reg, head_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic             ok_reg, ok_next;
    logic [IW-1:0]    ev_slot_reg, ev_slot_next;
    logic [CB-1:0]    cx_reg, cx_next;
    logic [CB-1:0]    cy_reg, cy_next;
    logic [CB-1:0]    shelf_reg, shelf_next;
    logic             rv_reg, rv_next;
    gcsa_pkg::res_t   res_reg, res_next;

    // Placement helpers.
    logic             zero_size;
    logic             too_wide;
    logic [CB:0]      x_sum;
    logic             wrap;
    logic [CB-1:0]    nx;
    logic [CB-1:0]    ny;
    logic [CB-1:0]    nsh;
    logic [CB:0]      y_sum;
    logic             too_tall;
    logic [CW:0]      tail_sum;
    logic [CW:0]      tail_wrap;
    logic             hit;

    // Scan compare on the registered entry read issued in the previous cycle.
    assign hit             = pend_reg && ok_reg && (ent_q.glyph == req_reg.glyph_id);
    assign stat.hit        = hit;
    assign stat.scan_done  = (idx_reg >= fill_reg) && !pend_reg;
    assign stat.table_full = (count_reg == N_CNT);

    // Shelf placement arithmetic.
    always_comb
    begin
        zero_size = (req_reg.bmp_width == '0) || (req_reg.bmp_height == '0);
        too_wide  = (req_reg.bmp_width > aw_reg);
        x_sum     = {1'b0, cx_reg} + {1'b0, req_reg.bmp_width};
        wrap      = (x_sum > {1'b0, aw_reg});
        nx        = wrap ? '0 : cx_reg;
        ny        = wrap ? CB'(cy_reg + shelf_reg) : cy_reg;
        nsh       = wrap ? '0 : shelf_reg;
        y_sum     = {1'b0, ny} + {1'b0, req_reg.bmp_height};
        too_tall  = (y_sum > {1'b0, ah_reg});
        tail_sum  = (CW+1)'(head_reg) + (CW+1)'(count_reg);
        tail_wrap = (tail_sum >= N_SUM) ? (tail_sum - N_SUM) : tail_sum;
    end

    // Next-state logic.
    always_comb
    begin
        req_next       = req_reg;
        aw_next        = aw_reg;
        ah_next        = ah_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        hole_v_next    = hole_v_reg;
        hole_slot_next = hole_slot_reg;
        head_next      = head_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        ok_next        = ok_reg;
        ev_slot_next   = ev_slot_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        shelf_next     = shelf_reg;
        rv_next        = 1'b0;
        res_next       = res_reg;
        ent_we         = 1'b0;
        ent_wa         = hole_v_reg ? hole_slot_reg : fill_reg[IW-1:0];
        ent_wd         = '0;
        ent_ra         = idx_reg[IW-1:0];
        ring_we        = 1'b0;
        ring_wa        = tail_wrap[IW-1:0];

        // Configuration writes.
        if (cfg_valid)
        begin
            if (cfg_index == gcsa_pkg::REG_ATLAS_WIDTH)
            begin
                aw_next = cfg_data;
            end
            else
            begin
                ah_next = cfg_data;
            end
        end

        // Capture a new request.
        if (cmd.load)
        begin
            req_next = req;
            idx_next = '0;
            pend_next = 1'b0;
            res_next = '0;
        end

        // Walk the filled part of the table, one entry a cycle.
        if (cmd.scan)
        begin
            if (idx_reg < fill_reg)
            begin
                pend_next = 1'b1;
                ok_next   = !(hole_v_reg && (idx_reg[IW-1:0] == hole_slot_reg));
                idx_next  = idx_reg + 1'b1;
            end
            else
            begin
                pend_next = 1'b0;
            end
            if (hit)
            begin
                res_next.status      = gcsa_pkg::ST_HIT;
                res_next.rect_left   = ent_q.rect.left;
                res_next.rect_top    = ent_q.rect.top;
                res_next.rect_right  = ent_q.rect.right;
                res_next.rect_bottom = ent_q.rect.bottom;
                rv_next              = 1'b1;
            end
        end

        // Fetch the oldest entry named by the order ring.
        if (cmd.ev_entry)
        begin
            ent_ra       = ring_q;
            ev_slot_next = ring_q;
        end

        // Drop the oldest entry, leaving a hole for the next insert.
        if (cmd.evict)
        begin
            res_next.evicted    = 1'b1;
            res_next.evicted_id = ent_q.glyph;
            hole_v_next         = 1'b1;
            hole_slot_next      = ev_slot_reg;
            head_next           = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
            count_next          = count_reg - 1'b1;
        end

        // Place the glyph on the current or next shelf, or report it empty or full.
        if (cmd.place)
        begin
            rv_next         = 1'b1;
            res_next.status = gcsa_pkg::ST_FULL;
            if (zero_size)
            begin
                res_next.status = gcsa_pkg::ST_EMPTY;
                ent_we          = 1'b1;
            end
            else if (!too_wide)
            begin
                cx_next    = nx;
                cy_next    = ny;
                shelf_next = nsh;
                if (!too_tall)
                begin
                    res_next.status      = gcsa_pkg::ST_PLACED;
                    res_next.rect_left   = nx;
                    res_next.rect_top    = ny;
                    res_next.rect_right  = CB'(nx + req_reg.bmp_width);
                    res_next.rect_bottom = y_sum[CB-1:0];
                    ent_we               = 1'b1;
                    cx_next              = CB'(nx + req_reg.bmp_width);
                    shelf_next = (req_reg.bmp_height > nsh) ? req_reg.bmp_height : nsh;
                end
            end
            if (ent_we)
            begin
                ent_wd.glyph       = req_reg.glyph_id;
                ent_wd.rect.left   = res_next.rect_left;
                ent_wd.rect.top    = res_next.rect_top;
                ent_wd.rect.right  = res_next.rect_right;
                ent_wd.rect.bottom = res_next.rect_bottom;
                ring_we            = 1'b1;
                count_next         = count_reg + 1'b1;
                if (hole_v_reg)
                begin
                    hole_v_next = 1'b0;
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
        end
    end

    // Memory ports, read data registered.
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            entry_mem[ent_wa] <= ent_wd;
        end
        ent_q <= entry_mem[ent_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_wa] <= ent_wa;
        end
        ring_q <= ring_mem[head_reg];
    end

    // Control and configuration state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aw_reg     <= gcsa_pkg::ATLAS_RESET;
            ah_reg     <= gcsa_pkg::ATLAS_RESET;
            fill_reg   <= '0;
            count_reg  <= '0;
            hole_v_reg <= 1'b0;
            head_reg   <= '0;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            shelf_reg  <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            aw_reg     <= aw_next;
            ah_reg     <= ah_next;
            fill_reg   <= fill_next;
            count_reg  <= count_next;
            hole_v_reg <= hole_v_next;
            head_reg   <= head_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            shelf_reg  <= shelf_next;
            rv_reg     <= rv_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        hole_slot_reg <= hole_slot_next;
        ok_reg        <= ok_next;
        ev_slot_reg   <= ev_slot_next;
        res_reg       <= res_next;
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule

/* rtl/gcsa_checker.sv */
// ----------------------------------------------------------------------------
// Glyph cache port checker
// Watches the top level ports for request and result sequencing.
// ----------------------------------------------------------------------------
module gcsa_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           result_valid,
    input gcsa_pkg::res_t result
);

    // A result beat closes the request, so the block is free again.
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result beat while still busy");

    // An accepted request keeps the block busy in the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // Results never come in consecutive cycles.
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("two result beats in a row");

    // A hit never evicts anything.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status == gcsa_pkg::ST_HIT))
            |-> (!result.evicted && (result.evicted_id == '0)))
        else $error("hit reports an eviction");

    // Without an eviction the evicted id reads zero.
    a_evict_id: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.evicted) |-> (result.evicted_id == '0))
        else $error("evicted id set without eviction");

endmodule

bind glyph_cache_shelf_allocator_top gcsa_checker u_gcsa_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
